// ===== hdl/delayed_message_queue_defines.svh =====
// Assertion macros used by the delayed message queue engine (dmq_back).
`ifndef DELAYED_MESSAGE_QUEUE_DEFINES_SVH
`define DELAYED_MESSAGE_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define DMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define DMQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DMQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/dmq_pkg.sv =====
// Types, constants and helpers of the delayed message queue.
package dmq_pkg;

    localparam int QUEUE_DEPTH       = 16;
    localparam int PAYLOAD_MAX_BYTES = 8;

    localparam int OPCODE_W  = 2;
    localparam int KIND_W    = 32;
    localparam int PAYLOAD_W = 64;
    localparam int BYTES_W   = 4;
    localparam int DELAY_W   = 32;
    localparam int TIME_W    = 48;
    localparam int DUE_W     = 49;
    localparam int LANES     = PAYLOAD_W / 8;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_IDX_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Raw opcodes on the input word
    localparam logic [OPCODE_W-1:0] OPC_POST   = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_GET    = 2'd1;
    localparam logic [OPCODE_W-1:0] OPC_REMOVE = 2'd2;

    // Classified command
    typedef enum logic [1:0] {
        CMD_POST,
        CMD_GET,
        CMD_REMOVE,
        CMD_REJECT
    } t_cmd_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_back_state;

    typedef struct packed {
        t_cmd_kind              cmd;
        logic [KIND_W-1:0]      kind;
        logic [PAYLOAD_W-1:0]   payload;
        logic [BYTES_W-1:0]     bytes;
        logic [DUE_W-1:0]       due;
        logic [TIME_W-1:0]      now;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [PAYLOAD_W-1:0]   payload;
        logic [BYTES_W-1:0]     bytes;
        logic [DUE_W-1:0]       due;
    } t_entry;

    typedef struct packed {
        logic                   ok;
        logic [KIND_W-1:0]      kind;
        logic [PAYLOAD_W-1:0]   payload;
        logic [BYTES_W-1:0]     bytes;
    } t_result;

    localparam t_result RESULT_FAIL = '{ok: 1'b0, kind: '0, payload: '0, bytes: '0};
    localparam t_result RESULT_PASS = '{ok: 1'b1, kind: '0, payload: '0, bytes: '0};

endpackage

// ===== hdl/dmq_in_if.sv =====
// Input word channel of the delayed message queue.
interface dmq_in_if;
    logic                           valid;
    logic                           ready;
    logic [dmq_pkg::OPCODE_W-1:0]   opcode;
    logic [dmq_pkg::KIND_W-1:0]     msg_kind;
    logic [dmq_pkg::PAYLOAD_W-1:0]  payload;
    logic [dmq_pkg::BYTES_W-1:0]    payload_bytes;
    logic [dmq_pkg::DELAY_W-1:0]    delay_ms;
    logic [dmq_pkg::TIME_W-1:0]     now_ms;

    modport source (
        output valid, opcode, msg_kind, payload, payload_bytes, delay_ms, now_ms,
        input  ready
    );
    modport sink (
        input  valid, opcode, msg_kind, payload, payload_bytes, delay_ms, now_ms,
        output ready
    );
endinterface

// ===== hdl/dmq_out_if.sv =====
// Result word channel of the delayed message queue.
interface dmq_out_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic [dmq_pkg::KIND_W-1:0]     out_kind;
    logic [dmq_pkg::PAYLOAD_W-1:0]  out_payload;
    logic [dmq_pkg::BYTES_W-1:0]    out_bytes;

    modport source (
        output valid, ok, out_kind, out_payload, out_bytes,
        input  ready
    );
    modport sink (
        input  valid, ok, out_kind, out_payload, out_bytes,
        output ready
    );
endinterface

// ===== hdl/dmq_front.sv =====
// Front end: accepts input words, decodes them and prepares due time and payload.
module dmq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dmq_in_if.sink          i_in,
    output logic            o_cmd_vld,
    input  logic            i_cmd_rdy,
    output dmq_pkg::t_cmd   o_cmd
);

    logic                           r_vld;
    dmq_pkg::t_cmd                  r_cmd;
    dmq_pkg::t_cmd                  n_cmd;
    logic [dmq_pkg::BYTES_W-1:0]    bytes_sat;

    // Take a new word whenever the stage is empty or draining
    assign i_in.ready = !r_vld || i_cmd_rdy;

    // Decode, saturate the length, mask unused bytes and form the due time
    always_comb begin
        if (i_in.payload_bytes > dmq_pkg::BYTES_W'(dmq_pkg::PAYLOAD_MAX_BYTES)) begin
            bytes_sat = dmq_pkg::BYTES_W'(dmq_pkg::PAYLOAD_MAX_BYTES);
        end else begin
            bytes_sat = i_in.payload_bytes;
        end
        unique case (i_in.opcode)
            dmq_pkg::OPC_POST:   n_cmd.cmd = dmq_pkg::CMD_POST;
            dmq_pkg::OPC_GET:    n_cmd.cmd = dmq_pkg::CMD_GET;
            dmq_pkg::OPC_REMOVE: n_cmd.cmd = dmq_pkg::CMD_REMOVE;
            default:             n_cmd.cmd = dmq_pkg::CMD_REJECT;
        endcase
        n_cmd.kind  = i_in.msg_kind;
        n_cmd.bytes = bytes_sat;
        n_cmd.now   = i_in.now_ms;
        n_cmd.due   = dmq_pkg::DUE_W'(i_in.now_ms) + dmq_pkg::DUE_W'(i_in.delay_ms);
        for (int b = 0; b < dmq_pkg::LANES; b++) begin
            if (dmq_pkg::BYTES_W'(b) < bytes_sat) begin
                n_cmd.payload[b*8 +: 8] = i_in.payload[b*8 +: 8];
            end else begin
                n_cmd.payload[b*8 +: 8] = 8'd0;
            end
        end
    end

    // Hold the decoded word until the command queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_vld = r_vld;
    assign o_cmd     = r_cmd;

endmodule

// ===== hdl/dmq_cmd_fifo.sv =====
// Short command queue between the front end and the queue engine.
module dmq_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_vld,
    output logic            o_push_rdy,
    input  dmq_pkg::t_cmd   i_push_cmd,
    output logic            o_pop_vld,
    input  logic            i_pop_rdy,
    output dmq_pkg::t_cmd   o_pop_cmd
);

    dmq_pkg::t_cmd                      r_slot [dmq_pkg::CMDQ_DEPTH];
    logic [dmq_pkg::CMDQ_IDX_W-1:0]     r_wptr;
    logic [dmq_pkg::CMDQ_IDX_W-1:0]     r_rptr;
    logic [dmq_pkg::CMDQ_CNT_W-1:0]     r_fill;
    logic                               push;
    logic                               pop;

    assign o_push_rdy = (r_fill != dmq_pkg::CMDQ_CNT_W'(dmq_pkg::CMDQ_DEPTH));
    assign o_pop_vld  = (r_fill != '0);
    assign o_pop_cmd  = r_slot[r_rptr];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                if (r_wptr == dmq_pkg::CMDQ_IDX_W'(dmq_pkg::CMDQ_DEPTH - 1)) begin
                    r_wptr <= '0;
                end else begin
                    r_wptr <= r_wptr + 1'b1;
                end
            end
            if (pop) begin
                if (r_rptr == dmq_pkg::CMDQ_IDX_W'(dmq_pkg::CMDQ_DEPTH - 1)) begin
                    r_rptr <= '0;
                end else begin
                    r_rptr <= r_rptr + 1'b1;
                end
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

endmodule

// ===== hdl/dmq_back.sv =====
// Queue engine: message store, scan-and-compact sequencer and result register.
`include "delayed_message_queue_defines.svh"

module dmq_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_vld,
    output logic            o_cmd_rdy,
    input  dmq_pkg::t_cmd   i_cmd,
    dmq_out_if.source       o_out
);

    // Message store, insertion order from index zero
    dmq_pkg::t_entry                mem [dmq_pkg::QUEUE_DEPTH];

    dmq_pkg::t_back_state           r_state, n_state;
    logic [dmq_pkg::CNT_W-1:0]      r_count, n_count;
    dmq_pkg::t_cmd                  r_cmd, n_cmd;
    logic [dmq_pkg::CNT_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic                           r_rd_vld, n_rd_vld;
    dmq_pkg::t_entry                r_rd_data;
    logic [dmq_pkg::CNT_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic                           r_found, n_found;
    dmq_pkg::t_entry                r_hit, n_hit;
    logic                           r_out_vld, n_out_vld;
    dmq_pkg::t_result               r_out, n_out;

    logic                           out_free;
    logic                           skip;
    logic                           mem_we;
    logic [dmq_pkg::IDX_W-1:0]      mem_waddr;
    dmq_pkg::t_entry                mem_wdata;
    logic [dmq_pkg::IDX_W-1:0]      rd_addr;

    assign out_free = !r_out_vld || o_out.ready;
    assign rd_addr  = r_rd_ptr[dmq_pkg::IDX_W-1:0];

    // Sequence post, scan-and-compact and result hand-off
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cmd     = r_cmd;
        n_rd_ptr  = r_rd_ptr;
        n_rd_vld  = 1'b0;
        n_wr_ptr  = r_wr_ptr;
        n_found   = r_found;
        n_hit     = r_hit;
        n_out_vld = r_out_vld && !o_out.ready;
        n_out     = r_out;
        o_cmd_rdy = 1'b0;
        skip      = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_wr_ptr[dmq_pkg::IDX_W-1:0];
        mem_wdata = r_rd_data;

        unique case (r_state)
            dmq_pkg::ST_IDLE: begin
                o_cmd_rdy = out_free;
                if (i_cmd_vld && out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = dmq_pkg::RESULT_FAIL;
                    unique case (i_cmd.cmd)
                        dmq_pkg::CMD_POST: begin
                            if (r_count < dmq_pkg::CNT_W'(dmq_pkg::QUEUE_DEPTH)) begin
                                mem_we            = 1'b1;
                                mem_waddr         = r_count[dmq_pkg::IDX_W-1:0];
                                mem_wdata.kind    = i_cmd.kind;
                                mem_wdata.payload = i_cmd.payload;
                                mem_wdata.bytes   = i_cmd.bytes;
                                mem_wdata.due     = i_cmd.due;
                                n_count           = r_count + 1'b1;
                                n_out             = dmq_pkg::RESULT_PASS;
                            end
                        end
                        dmq_pkg::CMD_GET, dmq_pkg::CMD_REMOVE: begin
                            if (r_count != '0) begin
                                n_out_vld = r_out_vld && !o_out.ready;
                                n_out     = r_out;
                                n_cmd     = i_cmd;
                                n_rd_ptr  = '0;
                                n_wr_ptr  = '0;
                                n_found   = 1'b0;
                                n_state   = dmq_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            n_out = dmq_pkg::RESULT_FAIL;
                        end
                    endcase
                end
            end

            dmq_pkg::ST_SCAN: begin
                // Issue the next read
                if (r_rd_ptr != r_count) begin
                    n_rd_vld = 1'b1;
                    n_rd_ptr = r_rd_ptr + 1'b1;
                end
                // Drop matching entries (every kind match on remove, the first due one on get), copy the others down
                if (r_rd_vld) begin
                    if (r_cmd.cmd == dmq_pkg::CMD_REMOVE) begin
                        skip = (r_rd_data.kind == r_cmd.kind);
                    end else begin
                        skip = !r_found && ({1'b0, r_cmd.now} >= r_rd_data.due);
                    end
                    if (skip) begin
                        if (r_cmd.cmd == dmq_pkg::CMD_GET) begin
                            n_found = 1'b1;
                            n_hit   = r_rd_data;
                        end
                    end else begin
                        mem_we   = 1'b1;
                        n_wr_ptr = r_wr_ptr + 1'b1;
                    end
                end
                if (r_rd_ptr == r_count && !r_rd_vld) begin
                    n_state = dmq_pkg::ST_FINISH;
                end
            end

            dmq_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_count   = r_wr_ptr;
                    n_out_vld = 1'b1;
                    n_state   = dmq_pkg::ST_IDLE;
                    if (r_cmd.cmd == dmq_pkg::CMD_GET) begin
                        if (r_found) begin
                            n_out.ok      = 1'b1;
                            n_out.kind    = r_hit.kind;
                            n_out.payload = r_hit.payload;
                            n_out.bytes   = r_hit.bytes;
                        end else begin
                            n_out = dmq_pkg::RESULT_FAIL;
                        end
                    end else begin
                        n_out = dmq_pkg::RESULT_PASS;
                    end
                end
            end

            default: begin
                n_state = dmq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dmq_pkg::ST_IDLE;
            r_count   <= '0;
            r_rd_ptr  <= '0;
            r_rd_vld  <= 1'b0;
            r_wr_ptr  <= '0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_ptr  <= n_rd_ptr;
            r_rd_vld  <= n_rd_vld;
            r_wr_ptr  <= n_wr_ptr;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_hit <= n_hit;
        r_out <= n_out;
    end

    // Store write port and registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.ok          = r_out.ok;
    assign o_out.out_kind    = r_out.kind;
    assign o_out.out_payload = r_out.payload;
    assign o_out.out_bytes   = r_out.bytes;

    `DMQ_ASSERT(a_count_in_range, i_clk, i_rst_n, r_count <= dmq_pkg::CNT_W'(dmq_pkg::QUEUE_DEPTH), "stored count beyond depth")
    `DMQ_ASSERT(a_wr_behind_rd, i_clk, i_rst_n, (r_state == dmq_pkg::ST_SCAN) |-> (r_wr_ptr <= r_rd_ptr), "compaction write overtook read")
    `DMQ_ASSERT(a_hit_only_get, i_clk, i_rst_n, (r_state == dmq_pkg::ST_SCAN && r_found) |-> (r_cmd.cmd == dmq_pkg::CMD_GET), "hit captured outside get")
    `DMQ_ASSERT(a_finish_result, i_clk, i_rst_n, (r_state == dmq_pkg::ST_FINISH && out_free) |=> (r_out_vld && r_state == dmq_pkg::ST_IDLE), "scan end gave no result")
    `DMQ_ASSERT_ALWAYS(a_no_cmd_in_scan, i_clk, (r_state != dmq_pkg::ST_IDLE) |-> !o_cmd_rdy, "command taken during scan")

endmodule

// ===== hdl/delayed_message_queue.sv =====
// Delayed message queue: a post, an unused opcode, or a get or remove on an empty queue
// passes the front register and the command queue and sets the result register directly. Other
// gets and removes scan the store: the engine reads and compacts one stored message a cycle
// through a single store read port and one write port, and a stalled result holds the engine.
// One word is in service in the engine at a time; three more may wait in front of it.
// Synchronous active-low reset empties the queue; stored message contents are kept.
module delayed_message_queue (
    input  logic    i_clk,
    input  logic    i_rst_n,
    dmq_in_if.sink  i_in,
    dmq_out_if.source o_out
);

    logic           front_vld;
    logic           front_rdy;
    dmq_pkg::t_cmd  front_cmd;
    logic           back_vld;
    logic           back_rdy;
    dmq_pkg::t_cmd  back_cmd;

    // Decode input words
    dmq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_cmd_vld (front_vld),
        .i_cmd_rdy (front_rdy),
        .o_cmd     (front_cmd)
    );

    // Buffer commands between decode and engine
    dmq_cmd_fifo u_cmd_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (front_vld),
        .o_push_rdy (front_rdy),
        .i_push_cmd (front_cmd),
        .o_pop_vld  (back_vld),
        .i_pop_rdy  (back_rdy),
        .o_pop_cmd  (back_cmd)
    );

    // Execute commands on the message store
    dmq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (back_vld),
        .o_cmd_rdy (back_rdy),
        .i_cmd     (back_cmd),
        .o_out     (o_out)
    );

endmodule

// ===== tb/delayed_message_queue_test.sv =====
// Self-checking testbench of the delayed message queue: directed table, then random words.
module delayed_message_queue_test;

    // Opcode left unused by the block
    localparam logic [dmq_pkg::OPCODE_W-1:0] OPC_UNUSED = 2'd3;
    localparam int RANDOM_WORDS   = 950;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        logic [dmq_pkg::OPCODE_W-1:0]  opc;
        logic [dmq_pkg::KIND_W-1:0]    kind;
        logic [dmq_pkg::PAYLOAD_W-1:0] payload;
        logic [dmq_pkg::BYTES_W-1:0]   bytes;
        logic [dmq_pkg::DELAY_W-1:0]   delay;
        logic [dmq_pkg::TIME_W-1:0]    now;
    } t_word;

    typedef struct packed {
        t_word              word;
        logic [4:0]         reps;
        logic               typed;
        dmq_pkg::t_result   want;
    } t_plan_row;

    logic clk;
    logic rst_n;
    logic calm;

    dmq_in_if  in_ch ();
    dmq_out_if out_ch ();

    delayed_message_queue uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the stored messages
    dmq_pkg::t_entry    shadow_msgs [dmq_pkg::QUEUE_DEPTH];
    int                 shadow_count;
    dmq_pkg::t_result   pending_results [$];
    t_plan_row          plan [$];
    logic [dmq_pkg::TIME_W-1:0] clock_ms;
    int          mismatch_count;
    int          idle_cycles;
    int          stall_left;

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Close the gap left by a removed message
    function automatic void drop_msg(input int slot);
        int k;
        for (k = slot; k + 1 < shadow_count; k++)
            shadow_msgs[k] = shadow_msgs[k + 1];
        shadow_count--;
    endfunction

    // Apply one word to the shadow queue and return the result it should give
    function automatic dmq_pkg::t_result queue_apply(input t_word w);
        dmq_pkg::t_result   res;
        dmq_pkg::t_entry    fresh;
        logic [dmq_pkg::BYTES_W-1:0] n;
        int         i;
        int         k;
        bit         found;
        res = dmq_pkg::RESULT_FAIL;
        case (w.opc)
            dmq_pkg::OPC_POST: begin
                if (shadow_count < dmq_pkg::QUEUE_DEPTH) begin
                    n = (w.bytes > dmq_pkg::PAYLOAD_MAX_BYTES)
                        ? dmq_pkg::BYTES_W'(dmq_pkg::PAYLOAD_MAX_BYTES) : w.bytes;
                    fresh.kind    = w.kind;
                    fresh.bytes   = n;
                    fresh.payload = '0;
                    for (k = 0; k < n; k++)
                        fresh.payload[k*8 +: 8] = w.payload[k*8 +: 8];
                    fresh.due = {1'b0, w.now} + dmq_pkg::DUE_W'(w.delay);
                    shadow_msgs[shadow_count] = fresh;
                    shadow_count++;
                    res = dmq_pkg::RESULT_PASS;
                end
            end
            dmq_pkg::OPC_GET: begin
                found = 1'b0;
                for (i = 0; i < shadow_count && !found; i++) begin
                    if ({1'b0, w.now} >= shadow_msgs[i].due) begin
                        found       = 1'b1;
                        res.ok      = 1'b1;
                        res.kind    = shadow_msgs[i].kind;
                        res.payload = shadow_msgs[i].payload;
                        res.bytes   = shadow_msgs[i].bytes;
                        drop_msg(i);
                    end
                end
            end
            dmq_pkg::OPC_REMOVE: begin
                if (shadow_count > 0) begin
                    res = dmq_pkg::RESULT_PASS;
                    i = 0;
                    while (i < shadow_count) begin
                        if (shadow_msgs[i].kind == w.kind)
                            drop_msg(i);
                        else
                            i++;
                    end
                end
            end
            default: res = dmq_pkg::RESULT_FAIL;
        endcase
        return res;
    endfunction

    // Random word; the mode leans the mix towards filling, draining or removing
    function automatic t_word random_word(input int mode);
        t_word w;
        int    r;
        int    t_post;
        int    t_get;
        int    t_rem;
        case (mode)
            1:       begin t_post = 80; t_get = 92; t_rem = 98; end
            2:       begin t_post = 20; t_get = 90; t_rem = 98; end
            3:       begin t_post = 50; t_get = 65; t_rem = 97; end
            default: begin t_post = 45; t_get = 85; t_rem = 97; end
        endcase
        r = $urandom_range(0, 99);
        if (r < t_post)
            w.opc = dmq_pkg::OPC_POST;
        else if (r < t_get)
            w.opc = dmq_pkg::OPC_GET;
        else if (r < t_rem)
            w.opc = dmq_pkg::OPC_REMOVE;
        else
            w.opc = OPC_UNUSED;
        w.kind    = ($urandom_range(0, 4) != 0)
                    ? dmq_pkg::KIND_W'($urandom_range(0, 7)) : $urandom;
        w.payload = {$urandom, $urandom};
        w.bytes   = dmq_pkg::BYTES_W'($urandom_range(0, 15));
        r = $urandom_range(0, 9);
        if (r < 7)
            w.delay = $urandom_range(0, 60);
        else if (r < 9)
            w.delay = $urandom_range(0, 1000);
        else
            w.delay = $urandom;
        w.now = ($urandom_range(0, 15) != 0) ? clock_ms : {16'($urandom), $urandom};
        return w;
    endfunction

    function automatic void add_row(input t_word w, input int reps, input bit typed,
                                    input dmq_pkg::t_result want);
        t_plan_row row;
        row.word  = w;
        row.reps  = 5'(reps);
        row.typed = typed;
        row.want  = want;
        plan.insert(plan.size(), row);
    endfunction

    // Offer one word after a random gap and log its expected result once taken
    task automatic send_word(input t_word w, input bit typed, input dmq_pkg::t_result want);
        int                 gap;
        dmq_pkg::t_result   got;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= w.opc;
        in_ch.msg_kind      <= w.kind;
        in_ch.payload       <= w.payload;
        in_ch.payload_bytes <= w.bytes;
        in_ch.delay_ms      <= w.delay;
        in_ch.now_ms        <= w.now;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        got = queue_apply(w);
        pending_results.insert(pending_results.size(), typed ? want : got);
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: random stalls on ready
    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            out_ch.ready <= 1'b0;
            stall_left   <= pick_gap();
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge clk) begin
        dmq_pkg::t_result want;
        if (out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, got ok=%0d kind=%h payload=%h bytes=%0d",
                         $time, out_ch.ok, out_ch.out_kind, out_ch.out_payload, out_ch.out_bytes);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("ok", 64'(want.ok), 64'(out_ch.ok));
                report_field("out_kind", 64'(want.kind), 64'(out_ch.out_kind));
                report_field("out_payload", want.payload, out_ch.out_payload);
                report_field("out_bytes", 64'(want.bytes), 64'(out_ch.out_bytes));
            end
        end
    end

    // Stop a hung run: count cycles with no word moving on either side
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int mode;
        int phase_left;
        int sent;
        rst_n               = 1'b0;
        calm                = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.opcode        = dmq_pkg::OPC_POST;
        in_ch.msg_kind      = '0;
        in_ch.payload       = '0;
        in_ch.payload_bytes = '0;
        in_ch.delay_ms      = '0;
        in_ch.now_ms        = '0;
        out_ch.ready        = 1'b0;
        shadow_count        = 0;
        mismatch_count      = 0;
        idle_cycles         = 0;
        stall_left          = 0;
        clock_ms            = '0;
        mode                = 0;
        phase_left          = 0;
        sent                = 0;

        // Empty queue, then extremes of every field, then fill to the brim and empty again
        add_row('{dmq_pkg::OPC_GET, 32'd0, 64'd0, 4'd0, 32'd0, 48'd0}, 1, 1'b1,
                dmq_pkg::RESULT_FAIL);
        add_row('{dmq_pkg::OPC_REMOVE, 32'd0, 64'd0, 4'd0, 32'd0, 48'd0}, 1, 1'b1,
                dmq_pkg::RESULT_FAIL);
        add_row('{OPC_UNUSED, 32'd0, 64'd0, 4'd0, 32'd0, 48'd0}, 1, 1'b1,
                dmq_pkg::RESULT_FAIL);
        add_row('{dmq_pkg::OPC_POST, '1, '1, 4'd8, 32'd0, 48'd0}, 1, 1'b1,
                dmq_pkg::RESULT_PASS);
        add_row('{dmq_pkg::OPC_POST, 32'd0, '1, 4'd15, '1, '1}, 1, 1'b1,
                dmq_pkg::RESULT_PASS);
        add_row('{dmq_pkg::OPC_POST, 32'd1, '1, 4'd0, 32'd0, 48'd5}, 1, 1'b1,
                dmq_pkg::RESULT_PASS);
        add_row('{dmq_pkg::OPC_POST, 32'd2, 64'h0123_4567_89AB_CDEF, 4'd3, 32'd100, 48'd5},
                1, 1'b1, dmq_pkg::RESULT_PASS);
        add_row('{dmq_pkg::OPC_GET, 32'd0, 64'd0, 4'd0, 32'd0, 48'd0}, 1, 1'b1,
                '{ok: 1'b1, kind: '1, payload: '1, bytes: 4'd8});
        add_row('{dmq_pkg::OPC_GET, 32'd0, 64'd0, 4'd0, 32'd0, 48'd4}, 1, 1'b1,
                dmq_pkg::RESULT_FAIL);
        add_row('{dmq_pkg::OPC_GET, 32'd0, 64'd0, 4'd0, 32'd0, 48'd5}, 1, 1'b1,
                '{ok: 1'b1, kind: 32'd1, payload: '0, bytes: 4'd0});
        add_row('{dmq_pkg::OPC_GET, 32'd0, 64'd0, 4'd0, 32'd0, '1}, 1, 1'b0,
                dmq_pkg::RESULT_FAIL);
        add_row('{dmq_pkg::OPC_REMOVE, 32'd7, 64'd0, 4'd0, 32'd0, 48'd0}, 1, 1'b1,
                dmq_pkg::RESULT_PASS);
        add_row('{dmq_pkg::OPC_POST, 32'd3, 64'hA5A5_5A5A_F00F_0FF0, 4'd8, 32'd0, 48'd10},
                dmq_pkg::QUEUE_DEPTH - 1, 1'b1, dmq_pkg::RESULT_PASS);
        add_row('{dmq_pkg::OPC_POST, 32'd4, '1, 4'd8, 32'd0, 48'd10}, 1, 1'b1,
                dmq_pkg::RESULT_FAIL);
        add_row('{dmq_pkg::OPC_GET, 32'd0, 64'd0, 4'd0, 32'd0, '1}, 1, 1'b0,
                dmq_pkg::RESULT_FAIL);
        add_row('{dmq_pkg::OPC_REMOVE, 32'd3, 64'd0, 4'd0, 32'd0, 48'd0}, 1, 1'b1,
                dmq_pkg::RESULT_PASS);
        add_row('{dmq_pkg::OPC_REMOVE, 32'd0, 64'd0, 4'd0, 32'd0, 48'd0}, 1, 1'b1,
                dmq_pkg::RESULT_PASS);
        add_row('{dmq_pkg::OPC_REMOVE, 32'd0, 64'd0, 4'd0, 32'd0, 48'd0}, 1, 1'b1,
                dmq_pkg::RESULT_FAIL);
        add_row('{OPC_UNUSED, '1, '1, '1, '1, '1}, 1, 1'b1, dmq_pkg::RESULT_FAIL);

        // Hold reset low before releasing it
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[r]) begin
            for (int n = 0; n < plan[r].reps; n++)
                send_word(plan[r].word, plan[r].typed, plan[r].want);
        end

        // Random phases with a running millisecond clock
        while (sent < RANDOM_WORDS) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                mode       = $urandom_range(0, 3);
                calm      <= ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 7))
                    0:       clock_ms = 48'hFFFF_FFFF_FFFF
                                        - dmq_pkg::TIME_W'($urandom_range(0, 5000));
                    1:       clock_ms = {16'($urandom), $urandom};
                    default: clock_ms = clock_ms;
                endcase
            end
            clock_ms = clock_ms + dmq_pkg::TIME_W'($urandom_range(0, 20));
            send_word(random_word(mode), 1'b0, dmq_pkg::RESULT_FAIL);
            phase_left--;
            sent++;
        end
        in_ch.valid <= 1'b0;

        // Drain, then let the engine settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
